// ===== src/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned REQ_W     = 16;
  localparam int unsigned OFF_W     = 12;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned LARGEST_W = 15;
  localparam int unsigned HDR_W     = 16;
  localparam int unsigned CFG_W     = 13;

  localparam logic [CFG_W-1:0]     CFG_RESET   = 13'd4096;
  localparam logic [HDR_W-1:0]     HDR_MAX     = 16'hFFF8;
  localparam logic [LARGEST_W-1:0] LARGEST_SAT = 15'h7FFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic nxt_in;
    logic free;
    logic fits;
    logic big;
    logic merge_ok;
    logic split_ok;
  } walk_flags_t;

endpackage

// ===== src/ffha_if.sv =====
// ----------------------------------------------------------------------------
// ffha_if
// Command and response channels of the first-fit heap allocator.
// ----------------------------------------------------------------------------
interface ffha_cmd_if import ffha_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [REQ_W-1:0] request_bytes;
  logic [OFF_W-1:0] payload_offset;

  modport source (output valid, output command, output request_bytes,
                  output payload_offset, input ready);
  modport sink   (input valid, input command, input request_bytes,
                  input payload_offset, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [OFF_W-1:0]     result_offset;
  logic [LARGEST_W-1:0] largest_bytes;

  modport source (output valid, output status, output result_offset,
                  output largest_bytes, input ready);
  modport sink   (input valid, input status, input result_offset,
                  input largest_bytes, output ready);
endinterface

// ===== src/ffha_hdr_mem.sv =====
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// Block header store, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffha_hdr_mem import ffha_pkg::*; #(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [HDR_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [HDR_W-1:0] rdata_o
);

  logic [HDR_W-1:0] mem_q [DEPTH];
  logic [HDR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ffha_walk_unit.sv =====
// ----------------------------------------------------------------------------
// ffha_walk_unit
// Shared header arithmetic: next block, fit, merge and split values.
// ----------------------------------------------------------------------------
module ffha_walk_unit import ffha_pkg::*; #(
  parameter int unsigned POOL_WORDS = 4096,
  localparam int unsigned AW  = $clog2(POOL_WORDS),
  localparam int unsigned PW  = (AW + 1 > CFG_W) ? AW + 1 : CFG_W,
  localparam int unsigned NW  = ((AW > HDR_W - 3) ? AW : HDR_W - 3) + 1,
  localparam int unsigned NDW = NW + 3
) (
  input  logic [AW-1:0]    h_i,
  input  logic [HDR_W-1:0] v_i,
  input  logic [HDR_W-1:0] w_i,
  input  logic [NDW-1:0]   need_i,
  input  logic [HDR_W-1:0] largest_i,
  input  logic [PW-1:0]    p_i,
  output logic [NW-1:0]    nxt_o,
  output logic [HDR_W-1:0] sum_o,
  output logic [AW-1:0]    r_o,
  output logic [HDR_W-1:0] rem_o,
  output walk_flags_t      flags_o
);

  localparam int unsigned EW = NW + 3;
  localparam int unsigned RW = NW + 1;
  localparam logic [RW-1:0] DEPTH_R = RW'(POOL_WORDS);

  logic [NW-1:0]  nxt;
  logic [NW-1:0]  room;
  logic [EW-1:0]  ext;
  logic [EW-1:0]  sum_raw;
  logic [EW-1:0]  sum_ext;
  logic [HDR_W-1:0] sum;
  logic [NDW-1:0] need8;
  logic [RW-1:0]  r;

  always_comb begin
    nxt     = NW'(h_i) + NW'(1) + NW'(v_i[HDR_W-1:3]);
    room    = NW'(p_i) - NW'(h_i) - NW'(1);
    ext     = {room, 3'b000};
    sum_raw = EW'(v_i) + EW'(8) + EW'(w_i);
    sum_ext = (sum_raw > ext) ? ext : sum_raw;
    sum     = (sum_ext > EW'(HDR_MAX)) ? HDR_MAX : sum_ext[HDR_W-1:0];
    need8   = need_i + NDW'(8);
    r       = RW'(h_i) + RW'(1) + RW'(need_i >> 3);

    flags_o.nxt_in   = nxt < NW'(p_i);
    flags_o.free     = !v_i[0];
    flags_o.fits     = !v_i[0] && (NDW'(v_i) >= need_i);
    flags_o.big      = !v_i[0] && (v_i > largest_i);
    flags_o.merge_ok = !w_i[0] && (sum > v_i);
    flags_o.split_ok = (NDW'(v_i) >= need8) && (r < DEPTH_R);
  end

  assign nxt_o = nxt;
  assign sum_o = sum;
  assign r_o   = r[AW-1:0];
  assign rem_o = v_i - HDR_W'(8) - need_i[HDR_W-1:0];

endmodule

// ===== src/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Init writes the pool header; free reads a header and clears its used bit;
//   allocate walks the headers, merging free neighbours, then splits if there is
//   room and marks the block; query walks the headers twice; done waits on a full output.
// Commands are taken one at a time, the next taken while a result waits.
// Reset clears control and sets pool_words to 4096; headers need an init.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int unsigned POOL_WORDS = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  ffha_cmd_if.sink         cmd_i,
  ffha_rsp_if.source       rsp_o
);

  localparam int unsigned AW  = $clog2(POOL_WORDS);
  localparam int unsigned PW  = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam int unsigned NW  = ((AW > HDR_W - 3) ? AW : HDR_W - 3) + 1;
  localparam int unsigned NDW = NW + 3;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHK   = 9'b000000010,
    S_MRG   = 9'b000000100,
    S_SPLIT = 9'b000001000,
    S_MARK  = 9'b000010000,
    S_FRD   = 9'b000100000,
    S_DONE  = 9'b001000000,
    S_P2    = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_e;

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [CFG_W-1:0]     pool_q;
  logic [NDW-1:0]       need_q, need_d;
  logic [AW-1:0]        h_q, h_d;
  logic [AW-1:0]        nxt_q, nxt_d;
  logic [HDR_W-1:0]     v_q, v_d;
  logic                 vsel_q, vsel_d;
  logic                 pass2_q, pass2_d;
  logic [HDR_W-1:0]     largest_q, largest_d;
  status_e              res_status_q, res_status_d;
  logic [OFF_W-1:0]     res_roff_q, res_roff_d;
  logic [LARGEST_W-1:0] res_largest_q, res_largest_d;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [OFF_W-1:0]     out_roff_q;
  logic [LARGEST_W-1:0] out_largest_q;
  logic                 out_load;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [HDR_W-1:0]     mem_wdata, mem_rdata;

  logic [PW-1:0]        p;
  logic [PW-1:0]        pm1;
  logic [PW+2:0]        init_raw;
  logic [HDR_W-1:0]     init_size;
  logic [REQ_W:0]       req_up;
  logic [NDW-1:0]       alloc_need;
  logic [NDW-1:0]       query_need;
  logic                 off_bad;
  logic [AW-1:0]        off_idx;
  logic [AW:0]          h_p1;
  logic [HDR_W-1:0]     unit_v;
  logic [HDR_W-1:0]     big_v;
  logic [LARGEST_W-1:0] big_sat;
  logic [NW-1:0]        unit_nxt;
  logic [AW-1:0]        nxt_a;
  logic [HDR_W-1:0]     unit_sum;
  logic [AW-1:0]        unit_r;
  logic [HDR_W-1:0]     unit_rem;
  walk_flags_t          flags;
  logic                 cmd_acc;

  ffha_hdr_mem #(.DEPTH(POOL_WORDS)) u_hdr_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ffha_walk_unit #(.POOL_WORDS(POOL_WORDS)) u_walk_unit (
    .h_i       (h_q),
    .v_i       (unit_v),
    .w_i       (mem_rdata),
    .need_i    (need_q),
    .largest_i (largest_q),
    .p_i       (p),
    .nxt_o     (unit_nxt),
    .sum_o     (unit_sum),
    .r_o       (unit_r),
    .rem_o     (unit_rem),
    .flags_o   (flags)
  );

  // clamped pool size and per-command setup values
  always_comb begin
    if (pool_q < CFG_W'(2)) begin
      p = PW'(2);
    end else if (PW'(pool_q) > PW'(POOL_WORDS)) begin
      p = PW'(POOL_WORDS);
    end else begin
      p = PW'(pool_q);
    end
    pm1        = p - PW'(1);
    init_raw   = {pm1, 3'b000};
    init_size  = (init_raw > (PW+3)'(HDR_MAX)) ? HDR_MAX : init_raw[HDR_W-1:0];
    req_up     = {1'b0, cmd_i.request_bytes} + (REQ_W+1)'(7);
    alloc_need = NDW'({req_up[REQ_W:3], 3'b000});
    query_need = NDW'(init_raw);
    off_bad    = (cmd_i.payload_offset == '0) || (PW'(cmd_i.payload_offset) >= p);
    off_idx    = AW'(cmd_i.payload_offset - OFF_W'(1));
    h_p1       = (AW+1)'(h_q) + (AW+1)'(1);
    unit_v     = ((state_q == S_CHK) && !vsel_q) ? mem_rdata : v_q;
    big_v      = flags.big ? unit_v : largest_q;
    big_sat    = big_v[HDR_W-1] ? LARGEST_SAT : big_v[LARGEST_W-1:0];
    nxt_a      = unit_nxt[AW-1:0];
  end

  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    need_d        = need_q;
    h_d           = h_q;
    nxt_d         = nxt_q;
    v_d           = v_q;
    vsel_d        = vsel_q;
    pass2_d       = pass2_q;
    largest_d     = largest_q;
    res_status_d  = res_status_q;
    res_roff_d    = res_roff_q;
    res_largest_d = res_largest_q;
    mem_we        = 1'b0;
    mem_waddr     = h_q;
    mem_wdata     = v_q;
    mem_re        = 1'b0;
    mem_raddr     = h_q;
    out_load      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_acc) begin
          cmd_d         = cmd_e'(cmd_i.command);
          res_status_d  = ST_OK;
          res_roff_d    = '0;
          res_largest_d = '0;
          h_d           = '0;
          vsel_d        = 1'b0;
          pass2_d       = 1'b0;
          largest_d     = '0;
          case (cmd_e'(cmd_i.command))
            CMD_INIT: begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = init_size;
              state_d   = S_DONE;
            end
            CMD_ALLOC: begin
              need_d    = alloc_need;
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_d   = S_CHK;
            end
            CMD_FREE: begin
              if (off_bad) begin
                res_status_d = ST_RANGE;
                state_d      = S_DONE;
              end else begin
                h_d       = off_idx;
                mem_re    = 1'b1;
                mem_raddr = off_idx;
                state_d   = S_FRD;
              end
            end
            CMD_QUERY: begin
              need_d    = query_need;
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_d   = S_CHK;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_CHK: begin
        v_d    = unit_v;
        vsel_d = 1'b0;
        if (pass2_q) begin
          largest_d = big_v;
          if (flags.nxt_in) begin
            h_d       = nxt_a;
            mem_re    = 1'b1;
            mem_raddr = nxt_a;
          end else begin
            res_largest_d = big_sat;
            state_d       = S_DONE;
          end
        end else if (flags.fits) begin
          state_d = (cmd_q == CMD_QUERY) ? S_P2 : S_SPLIT;
        end else if (flags.free && flags.nxt_in) begin
          nxt_d     = nxt_a;
          mem_re    = 1'b1;
          mem_raddr = nxt_a;
          state_d   = S_MRG;
        end else if (flags.nxt_in) begin
          h_d       = nxt_a;
          mem_re    = 1'b1;
          mem_raddr = nxt_a;
        end else if (cmd_q == CMD_QUERY) begin
          state_d = S_P2;
        end else begin
          res_status_d = ST_NOFIT;
          state_d      = S_DONE;
        end
      end

      // second query pass starts over from word 0
      S_P2: begin
        pass2_d   = 1'b1;
        h_d       = '0;
        largest_d = '0;
        vsel_d    = 1'b0;
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_d   = S_CHK;
      end

      S_MRG: begin
        if (flags.merge_ok) begin
          mem_we    = 1'b1;
          mem_waddr = h_q;
          mem_wdata = unit_sum;
          v_d       = unit_sum;
          vsel_d    = 1'b1;
        end else begin
          h_d       = nxt_q;
          mem_re    = 1'b1;
          mem_raddr = nxt_q;
          vsel_d    = 1'b0;
        end
        state_d = S_CHK;
      end

      S_SPLIT: begin
        if (flags.split_ok) begin
          mem_we    = 1'b1;
          mem_waddr = unit_r;
          mem_wdata = unit_rem;
          v_d       = need_q[HDR_W-1:0];
        end
        state_d = S_MARK;
      end

      S_MARK: begin
        mem_we     = 1'b1;
        mem_waddr  = h_q;
        mem_wdata  = v_q | HDR_W'(1);
        res_roff_d = OFF_W'(h_p1);
        state_d    = S_DONE;
      end

      S_FRD: begin
        mem_we    = 1'b1;
        mem_waddr = h_q;
        mem_wdata = mem_rdata & ~HDR_W'(1);
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pool_q      <= CFG_RESET;
      out_valid_q <= 1'b0;
      pass2_q     <= 1'b0;
      vsel_q      <= 1'b0;
      cmd_q       <= CMD_INIT;
    end else begin
      state_q <= state_d;
      pass2_q <= pass2_d;
      vsel_q  <= vsel_d;
      cmd_q   <= cmd_d;
      if (cfg_we_i) begin
        pool_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    need_q        <= need_d;
    h_q           <= h_d;
    nxt_q         <= nxt_d;
    v_q           <= v_d;
    largest_q     <= largest_d;
    res_status_q  <= res_status_d;
    res_roff_q    <= res_roff_d;
    res_largest_q <= res_largest_d;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_roff_q    <= res_roff_q;
      out_largest_q <= res_largest_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.result_offset = out_roff_q;
  assign rsp_o.largest_bytes = out_largest_q;

endmodule

// ===== src/ffha_checker.sv =====
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the first-fit heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker import ffha_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cmd_valid_i,
  input logic                 cmd_ready_i,
  input logic                 rsp_valid_i,
  input logic                 rsp_ready_i,
  input logic [STAT_W-1:0]    rsp_status_i,
  input logic [OFF_W-1:0]     rsp_offset_i,
  input logic [LARGEST_W-1:0] rsp_largest_i
);

  logic [1:0] pend_q, pend_d;
  logic       cmd_xfer, rsp_xfer;

  assign cmd_xfer = cmd_valid_i && cmd_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (cmd_xfer && !rsp_xfer) begin
      pend_d = pend_q + 2'd1;
    end else if (!cmd_xfer && rsp_xfer) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_offset_i) && $stable(rsp_largest_i))
    else $error("response changed while stalled");

  // busy after a command transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_xfer |=> !cmd_ready_i)
    else $error("ready right after command transfer");

  // no response without an outstanding command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 2'd0)
    else $error("response without command");

  // failed commands carry zero payload
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_NOFIT || rsp_status_i == ST_RANGE)
      |-> rsp_offset_i == '0 && rsp_largest_i == '0)
    else $error("nonzero payload on failed command");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_offset_i  (rsp_o.result_offset),
  .rsp_largest_i (rsp_o.largest_bytes)
);
